// ===== sv/tlbp_pkg.sv =====
package tlbp_pkg;

    localparam int HISTORY_BITS    = 10;
    // history entries must be a power of two: the select is a field of the address
    localparam int HISTORY_ENTRIES = 128;
    localparam int HSEL_W          = $clog2(HISTORY_ENTRIES);
    localparam int PATTERN_ENTRIES = 1 << HISTORY_BITS;
    localparam int CTR_W           = 2;
    localparam int CNT_W           = 32;
    localparam int ADDR_W          = 32;

    localparam logic [CTR_W-1:0] CTR_MAX = CTR_W'(3);
    localparam logic [CTR_W-1:0] CTR_MIN = CTR_W'(0);
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = CTR_W'(2);

    localparam int CLEAR_LEN = (PATTERN_ENTRIES > HISTORY_ENTRIES) ?
                               PATTERN_ENTRIES : HISTORY_ENTRIES;
    localparam int CLR_W     = $clog2(CLEAR_LEN + 1);

    typedef struct packed {
        logic             clr_we;
        logic [CLR_W-1:0] clr_idx;
        logic             accept;
        logic             lookup;
        logic             update;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== sv/tlbp_in_if.sv =====
interface tlbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [tlbp_pkg::ADDR_W-1:0]   branch_address;
    logic                          taken;

    modport source (output valid, output branch_address, output taken, input ready);
    modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

// ===== sv/tlbp_out_if.sv =====
interface tlbp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         predicted_taken;
    logic                         prediction_correct;
    logic [tlbp_pkg::CNT_W-1:0]   miss_total;
    logic [tlbp_pkg::CNT_W-1:0]   branch_total;

    modport source (output valid, output predicted_taken, output prediction_correct,
                    output miss_total, output branch_total, input ready);
    modport sink   (input valid, input predicted_taken, input prediction_correct,
                    input miss_total, input branch_total, output ready);
endinterface

// ===== sv/tlbp_ctrl.sv =====
module tlbp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tlbp_pkg::t_sts  i_sts,
    output tlbp_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } t_state;

    t_state                       r_state, n_state;
    logic [tlbp_pkg::CLR_W-1:0]   r_clr_idx, n_clr_idx;

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == tlbp_pkg::CLR_W'(tlbp_pkg::CLEAR_LEN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.clr_we   = (r_state == S_CLEAR);
    assign o_cmd.clr_idx  = r_clr_idx;
    assign o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.lookup   = (r_state == S_LOOKUP);
    assign o_cmd.update   = (r_state == S_UPDATE) && i_sts.out_free;

endmodule

// ===== sv/tlbp_dp.sv =====
module tlbp_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlbp_pkg::t_cmd  i_cmd,
    output tlbp_pkg::t_sts  o_sts,
    tlbp_in_if.sink         i_br,
    tlbp_out_if.source      o_res
);

    logic [tlbp_pkg::HISTORY_BITS-1:0] hist_mem [tlbp_pkg::HISTORY_ENTRIES];
    logic [tlbp_pkg::CTR_W-1:0]        ctr_mem  [tlbp_pkg::PATTERN_ENTRIES];

    logic [tlbp_pkg::HSEL_W-1:0]       r_hsel;
    logic                              r_taken;
    logic [tlbp_pkg::HISTORY_BITS-1:0] r_hist;
    logic [tlbp_pkg::CTR_W-1:0]        r_ctr;

    logic                              r_out_valid;
    logic                              r_pred;
    logic                              r_ok;
    logic [tlbp_pkg::CNT_W-1:0]        r_miss, r_branch;

    logic                              pred;
    logic                              ok;
    logic [tlbp_pkg::CTR_W-1:0]        n_ctr;
    logic [tlbp_pkg::HISTORY_BITS-1:0] n_hist;
    logic                              hist_clr;

    assign pred     = (r_ctr >= tlbp_pkg::CTR_WEAK_TAKEN);
    assign ok       = (pred == r_taken);
    assign n_hist   = {r_hist[tlbp_pkg::HISTORY_BITS-2:0], r_taken};
    assign hist_clr = i_cmd.clr_we &&
                      (i_cmd.clr_idx < tlbp_pkg::CLR_W'(tlbp_pkg::HISTORY_ENTRIES));

    always_comb begin
        n_ctr = r_ctr;
        if (r_taken) begin
            if (r_ctr != tlbp_pkg::CTR_MAX) begin
                n_ctr = r_ctr + 1'b1;
            end
        end else begin
            if (r_ctr != tlbp_pkg::CTR_MIN) begin
                n_ctr = r_ctr - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_clr) begin
            hist_mem[i_cmd.clr_idx[tlbp_pkg::HSEL_W-1:0]] <= '0;
        end else if (i_cmd.update) begin
            hist_mem[r_hsel] <= n_hist;
        end
        if (i_cmd.accept) begin
            r_hist <= hist_mem[i_br.branch_address[tlbp_pkg::HSEL_W+1:2]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            ctr_mem[i_cmd.clr_idx[tlbp_pkg::HISTORY_BITS-1:0]] <= '0;
        end else if (i_cmd.update) begin
            ctr_mem[r_hist] <= n_ctr;
        end
        if (i_cmd.lookup) begin
            r_ctr <= ctr_mem[r_hist];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hsel  <= i_br.branch_address[tlbp_pkg::HSEL_W+1:2];
            r_taken <= i_br.taken;
        end
        if (i_cmd.update) begin
            r_pred <= pred;
            r_ok   <= ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_miss      <= '0;
            r_branch    <= '0;
        end else begin
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
                r_branch    <= r_branch + 1'b1;
                if (!ok) begin
                    r_miss <= r_miss + 1'b1;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free          = !r_out_valid || o_res.ready;
    assign o_res.valid             = r_out_valid;
    assign o_res.predicted_taken   = r_pred;
    assign o_res.prediction_correct = r_ok;
    assign o_res.miss_total        = r_miss;
    assign o_res.branch_total      = r_branch;

endmodule

// ===== sv/two_level_local_branch_predictor_unit.sv =====
// Two-level local branch predictor: address bits [8:2] pick a 10-bit local
// history, which indexes 1024 two-bit saturating counters; the result gives the
// prediction, whether it was right, and wrapping 32-bit miss and branch counts.
// Each item passes through three steps (accept with history read, counter read,
// update and result load), set by the two dependent registered memory reads; the
// update waits while an earlier result is still held, and no new item is accepted
// until it is done. After reset a clearing pass zeroes both tables, and no item is accepted until it ends.
module two_level_local_branch_predictor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlbp_in_if.sink     i_br,
    tlbp_out_if.source  o_res
);

    tlbp_pkg::t_cmd cmd;
    tlbp_pkg::t_sts sts;
    logic           in_ready;

    tlbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_br.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tlbp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_br    (i_br),
        .o_res   (o_res)
    );

    assign i_br.ready = in_ready;

endmodule

// ===== bench/tlbp_result_monitor.sv =====
`timescale 1ns / 1ps

module tlbp_result_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    tlbp_in_if   i_br,
    tlbp_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count,
    output int   o_hit_count
);

    typedef struct packed {
        logic                       predicted_taken;
        logic                       prediction_correct;
        logic [tlbp_pkg::CNT_W-1:0] miss_total;
        logic [tlbp_pkg::CNT_W-1:0] branch_total;
    } t_branch_verdict;

    logic [tlbp_pkg::HISTORY_BITS-1:0] local_hist  [tlbp_pkg::HISTORY_ENTRIES];
    logic [tlbp_pkg::CTR_W-1:0]        pattern_ctr [tlbp_pkg::PATTERN_ENTRIES];
    logic [tlbp_pkg::CNT_W-1:0]        miss_cnt;
    logic [tlbp_pkg::CNT_W-1:0]        branch_cnt;
    t_branch_verdict                   verdict_q [$];

    function automatic t_branch_verdict predict_branch(
        input logic [tlbp_pkg::ADDR_W-1:0] addr,
        input logic outcome
    );
        logic [tlbp_pkg::HSEL_W-1:0]       sel;
        logic [tlbp_pkg::HISTORY_BITS-1:0] hist;
        logic [tlbp_pkg::CTR_W-1:0]        ctr;
        t_branch_verdict                   v;
        sel  = addr[tlbp_pkg::HSEL_W+1:2];
        hist = local_hist[sel];
        ctr  = pattern_ctr[hist];
        v.predicted_taken    = (ctr >= tlbp_pkg::CTR_WEAK_TAKEN);
        v.prediction_correct = (v.predicted_taken == outcome);
        branch_cnt = branch_cnt + 1'b1;
        if (!v.prediction_correct) begin
            miss_cnt = miss_cnt + 1'b1;
        end
        if (outcome && ctr != tlbp_pkg::CTR_MAX) begin
            ctr = ctr + 1'b1;
        end else if (!outcome && ctr != tlbp_pkg::CTR_MIN) begin
            ctr = ctr - 1'b1;
        end
        pattern_ctr[hist] = ctr;
        local_hist[sel]   = {hist[tlbp_pkg::HISTORY_BITS-2:0], outcome};
        v.miss_total   = miss_cnt;
        v.branch_total = branch_cnt;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_branch_verdict want;
        if (!i_rst_n) begin
            foreach (local_hist[k]) local_hist[k] = '0;
            foreach (pattern_ctr[k]) pattern_ctr[k] = tlbp_pkg::CTR_MIN;
            miss_cnt       = '0;
            branch_cnt     = '0;
            o_fail_count   = 0;
            o_result_count = 0;
            o_hit_count    = 0;
            verdict_q.delete();
        end else begin
            if (i_br.valid && i_br.ready) begin
                verdict_q.push_back(predict_branch(i_br.branch_address, i_br.taken));
            end
            if (i_res.valid && i_res.ready) begin
                o_result_count++;
                if (verdict_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("[%0t] result %0d arrived with nothing pending",
                                 $realtime, o_result_count);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (i_res.prediction_correct) o_hit_count++;
                    if (i_res.predicted_taken !== want.predicted_taken ||
                        i_res.prediction_correct !== want.prediction_correct ||
                        i_res.miss_total !== want.miss_total ||
                        i_res.branch_total !== want.branch_total) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("[%0t] result %0d: exp pred=%0b ok=%0b miss=%0d br=%0d",
                                     $realtime, o_result_count, want.predicted_taken,
                                     want.prediction_correct, want.miss_total,
                                     want.branch_total);
                            $display("            got pred=%0b ok=%0b miss=%0d br=%0d",
                                     i_res.predicted_taken, i_res.prediction_correct,
                                     i_res.miss_total, i_res.branch_total);
                        end
                    end
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

// ===== bench/two_level_local_branch_predictor_unit_test.sv =====
`timescale 1ns / 1ps

module two_level_local_branch_predictor_unit_test;

    localparam int RANDOM_ITEMS = 1000;
    localparam int LOOP_SLOTS   = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    tlbp_in_if  br_ch ();
    tlbp_out_if res_ch ();

    int fail_count;
    int pending;
    int result_count;
    int hit_count;
    int sent;
    int directed_count;
    int holds_done;

    logic [tlbp_pkg::ADDR_W-1:0] loop_addr   [LOOP_SLOTS];
    logic [11:0]                 loop_bits   [LOOP_SLOTS];
    int                          loop_period [LOOP_SLOTS];
    int                          loop_pos    [LOOP_SLOTS];

    two_level_local_branch_predictor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_br    (br_ch),
        .o_res   (res_ch)
    );

    tlbp_result_monitor u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_br           (br_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_hit_count    (hit_count)
    );

    task automatic send_branch(input logic [tlbp_pkg::ADDR_W-1:0] addr, input logic outcome);
        br_ch.valid          <= 1'b1;
        br_ch.branch_address <= addr;
        br_ch.taken          <= outcome;
        do @(posedge i_clk); while (!br_ch.ready);
        sent++;
    endtask

    task automatic new_loop(input int k);
        loop_addr[k]   = $urandom;
        loop_bits[k]   = 12'($urandom);
        loop_period[k] = $urandom_range(1, 12);
        loop_pos[k]    = 0;
    endtask

    task automatic send_random_branch();
        int k;
        if ($urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, LOOP_SLOTS - 1);
            send_branch(loop_addr[k], loop_bits[k][loop_pos[k]]);
            loop_pos[k] = (loop_pos[k] + 1) % loop_period[k];
            if ($urandom_range(0, 99) == 0) new_loop(k);
        end else begin
            send_branch($urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int burst;
        int gap;
        i_rst_n              <= 1'b0;
        br_ch.valid          <= 1'b0;
        br_ch.branch_address <= '0;
        br_ch.taken          <= 1'b0;
        sent = 0;
        for (int k = 0; k < LOOP_SLOTS; k++) new_loop(k);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // counter floor, all-ones address, long taken run to saturate the top
        send_branch(32'h0000_0000, 1'b0);
        send_branch(32'hFFFF_FFFF, 1'b1);
        repeat (14) send_branch(32'hFFFF_FFFC, 1'b1);
        send_branch(32'hFFFF_FFFC, 1'b0);
        // byte offset and upper bits do not change the history select
        send_branch(32'h0000_0003, 1'b1);
        send_branch(32'h0000_0200, 1'b1);
        send_branch(32'h8000_0004, 1'b0);
        send_branch(32'h5555_5555, 1'b1);
        send_branch(32'hAAAA_AAAA, 1'b0);
        directed_count = sent;

        while (sent < directed_count + RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) send_random_branch();
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                br_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        br_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d branches (%0d directed), checked %0d results, %0d predicted right",
                 sent, directed_count, result_count, hit_count);
        $display("Output held off for long stretches %0d times", holds_done);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // result side: full-rate stretches, random stalls, a fixed stall pattern,
    // and long hold-offs that back the block up into its input
    initial begin
        int len;
        holds_done = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ((holds_done == 0 && sent >= 300) || (holds_done == 1 && sent >= 800)) begin
                holds_done++;
                res_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end else begin
                len = $urandom_range(5, 40);
                case ($urandom_range(0, 2))
                    0: begin
                        res_ch.ready <= 1'b1;
                        repeat (len) @(posedge i_clk);
                    end
                    1: begin
                        repeat (len) begin
                            res_ch.ready <= 1'($urandom_range(0, 1));
                            @(posedge i_clk);
                        end
                    end
                    default: begin
                        for (int k = 0; k < len; k++) begin
                            res_ch.ready <= (k % 3 == 2);
                            @(posedge i_clk);
                        end
                    end
                endcase
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Timed out with %0d branches sent", sent);
        $display("Verification failed");
        $finish;
    end

endmodule
